>>> hdl/ovng_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ovng_pkg
// Shared types and constants of the octave value noise grid.
// ---------------------------------------------------------------------------
package ovng_pkg;

	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int SEED_BITS_DEF   = 16;

	localparam int FRAC_BITS      = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int OCT_BITS       = 4;

	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH     = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCTAVE_COUNT   = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OCTAVE_FALLOFF = 2'd3;

	localparam logic [8:0]  GRID_WIDTH_RST     = 9'd256;
	localparam logic [8:0]  GRID_HEIGHT_RST    = 9'd256;
	localparam logic [3:0]  OCTAVE_COUNT_RST   = 4'd8;
	localparam logic [15:0] OCTAVE_FALLOFF_RST = 16'd2048;
	localparam logic [15:0] WEIGHT_ONE         = 16'd4096;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// quintic fade 6t^5 - 15t^4 + 10t^3
	localparam int FADE_C5 = 6;
	localparam int FADE_C4 = 15;
	localparam int FADE_C3 = 10;

	typedef enum logic [4:0] {
		S_IDLE,
		S_WX_GO,
		S_WX_WAIT,
		S_WY_GO,
		S_WY_WAIT,
		S_DX_GO,
		S_DX_WAIT,
		S_DY_GO,
		S_DY_WAIT,
		S_F1,
		S_F2,
		S_F3,
		S_F_GO,
		S_F_WAIT,
		S_RD,
		S_L_MUL,
		S_L_ADD,
		S_ACC_MUL,
		S_ACC_ADD,
		S_FIN_GO,
		S_FIN_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

>>> hdl/octave_value_noise_grid.sv
`default_nettype none
// ---------------------------------------------------------------------------
// octave_value_noise_grid
// Fractal value noise over a stored seed grid: seed writes and point
// computes through one sequencer around a seed RAM.
// ---------------------------------------------------------------------------
//  channel | signals                                   | direction
//  cfg     | cfg_we, cfg_index, cfg_data               | in, write only
//  in      | in_valid, in_stall, opcode, coord_*, seed | in
//  out     | out_valid, out_stall, height, point_*     | out
//
// A compute's length is set by the remainder unit, the fade divider and the
// four RAM reads per octave. Reset clears control state only; the seed RAM
// holds garbage until written. A result waiting on a stalled output holds the
// sequencer in its last step, and the input stays stalled meanwhile.
// ---------------------------------------------------------------------------
module octave_value_noise_grid #(
	parameter int MAX_WIDTH   = ovng_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = ovng_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_OCTAVES = ovng_pkg::MAX_OCTAVES_DEF,
	parameter int SEED_BITS   = ovng_pkg::SEED_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ovng_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [ovng_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                opcode,
	input  wire logic [7:0]                          coord_x,
	input  wire logic [7:0]                          coord_y,
	input  wire logic [15:0]                         seed_value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [15:0]                         height,
	output logic      [7:0]                          point_x,
	output logic      [7:0]                          point_y
);
	import ovng_pkg::*;

	localparam int GMAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int GB   = $clog2(GMAX + 1);
	localparam int CW   = (GB > 9) ? GB : 9;
	localparam int AW   = (GB > 8) ? GB : 8;
	localparam int AB   = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int TB   = 16 + $clog2(MAX_OCTAVES + 1);
	localparam int NW   = TB + SEED_BITS;
	localparam int FW   = 5 * GB;
	localparam int DW   = (FW > NW) ? FW : NW;
	localparam int QW   = 2 * GB + 4;
	localparam int LW   = SEED_BITS + 18;
	localparam int SB   = SEED_BITS;

	state_t state_q, state_d;

	// configuration
	logic [8:0]  gw_q, gh_q;
	logic [3:0]  oc_q;
	logic [15:0] fo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= GRID_WIDTH_RST;
			gh_q <= GRID_HEIGHT_RST;
			oc_q <= OCTAVE_COUNT_RST;
			fo_q <= OCTAVE_FALLOFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:     gw_q <= cfg_data[8:0];
				REG_GRID_HEIGHT:    gh_q <= cfg_data[8:0];
				REG_OCTAVE_COUNT:   oc_q <= cfg_data[3:0];
				REG_OCTAVE_FALLOFF: fo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped grid size and octave count
	logic [GB-1:0]       w, h, pxs, pys, px, py;
	logic [OCT_BITS-1:0] n_oct;
	logic [OCT_BITS-1:0] oct_q;

	always_comb begin
		if (gw_q < 9'd2) begin
			w = GB'(2);
		end else if (CW'(gw_q) > CW'(MAX_WIDTH)) begin
			w = GB'(MAX_WIDTH);
		end else begin
			w = GB'(gw_q);
		end
		if (gh_q < 9'd2) begin
			h = GB'(2);
		end else if (CW'(gh_q) > CW'(MAX_HEIGHT)) begin
			h = GB'(MAX_HEIGHT);
		end else begin
			h = GB'(gh_q);
		end
		if (oc_q == 4'd0) begin
			n_oct = 4'd1;
		end else if (oc_q > OCT_BITS'(MAX_OCTAVES)) begin
			n_oct = OCT_BITS'(MAX_OCTAVES);
		end else begin
			n_oct = oc_q;
		end
		pxs = w >> oct_q;
		pys = h >> oct_q;
		px  = (pxs == '0) ? GB'(1) : pxs;
		py  = (pys == '0) ? GB'(1) : pys;
	end

	// datapath registers
	logic [7:0]           cx_q, cy_q;
	logic [GB-1:0]        x_q, y_q, dx_q, dy_q, x1_q, x2_q, y1_q, y2_q;
	logic [GB-1:0]        fd_q, fp_q;
	logic [2*GB-1:0]      d2_q, p2_q, dp_q;
	logic [QW-1:0]        quad_q;
	logic [3*GB-1:0]      d3_q;
	logic [4*GB-1:0]      p4_q;
	logic [FW-1:0]        num_q, p5_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic                 fade_y_q;
	logic [SB-1:0]        seed_q [4];
	logic [2:0]           rd_cnt_q;
	logic [1:0]           lerp_cnt_q;
	logic signed [LW-1:0] prod_q;
	logic [SB-1:0]        top_q, bot_q, lerp_q;
	logic [SB+15:0]       nprod_q;
	logic [31:0]          wprod_q;
	logic [15:0]          weight_q;
	logic [NW-1:0]        noise_q;
	logic [TB-1:0]        total_q;
	logic                 out_valid_q;
	logic [15:0]          height_q;
	logic [7:0]           point_x_q, point_y_q;

	// remainder unit
	logic                 mod_start;
	logic [AW-1:0]        mod_a;
	logic [GB-1:0]        mod_b, mod_rem;
	div_stat_t            mod_stat;

	always_comb begin
		case (state_q)
			S_WX_GO: begin
				mod_a = AW'(cx_q);
				mod_b = w;
			end
			S_WY_GO: begin
				mod_a = AW'(cy_q);
				mod_b = h;
			end
			S_DY_GO: begin
				mod_a = AW'(y_q);
				mod_b = py;
			end
			default: begin
				mod_a = AW'(x_q);
				mod_b = px;
			end
		endcase
	end

	ovng_moddiv #(
		.DIVIDEND_BITS(AW),
		.DIVISOR_BITS (GB)
	) u_moddiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(mod_a),
		.divisor (mod_b),
		.rem     (mod_rem),
		.stat    (mod_stat)
	);

	// fraction divider, shared by fades and final normalization
	logic                 frac_start;
	logic [DW-1:0]        frac_num, frac_den;
	logic [FRAC_BITS-1:0] frac_quot;
	div_stat_t            frac_stat;

	assign frac_num = (state_q == S_FIN_GO) ? DW'(noise_q) : DW'(num_q);
	assign frac_den = (state_q == S_FIN_GO) ? DW'({total_q, {SB{1'b0}}}) : DW'(p5_q);

	ovng_fracdiv #(
		.DW(DW)
	) u_fracdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (frac_start),
		.num   (frac_num),
		.den   (frac_den),
		.quot  (frac_quot),
		.stat  (frac_stat)
	);

	// seed RAM
	logic                 in_acc;
	logic                 ram_we;
	logic [AB-1:0]        ram_waddr, ram_raddr;
	logic [SB-1:0]        ram_wdata, ram_rdata;
	logic [15+SB:0]       sv_wide;
	logic [GB-1:0]        rd_col, rd_row;

	assign in_acc    = in_valid && !in_stall;
	assign sv_wide   = {seed_value, {SB{1'b0}}};
	assign ram_wdata = sv_wide[15+SB -: SB];
	assign ram_we    = in_acc && (opcode == OP_WRITE) && (32'(coord_x) < MAX_WIDTH)
		&& (32'(coord_y) < MAX_HEIGHT);
	assign ram_waddr = AB'(coord_y) * AB'(MAX_WIDTH) + AB'(coord_x);
	assign rd_col    = rd_cnt_q[0] ? x2_q : x1_q;
	assign rd_row    = rd_cnt_q[1] ? y2_q : y1_q;
	assign ram_raddr = AB'(rd_row) * AB'(MAX_WIDTH) + AB'(rd_col);

	ovng_ram #(
		.WIDTH(SB),
		.DEPTH(MAX_WIDTH * MAX_HEIGHT)
	) u_seed_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// cell corners
	logic [GB-1:0] x1_n, y1_n, x2_n, y2_n;
	logic [GB:0]   x2_s, y2_s;

	assign x1_n = x_q - mod_rem;
	assign y1_n = y_q - mod_rem;
	assign x2_s = {1'b0, x1_n} + {1'b0, px};
	assign y2_s = {1'b0, y1_n} + {1'b0, py};
	assign x2_n = (x2_s >= {1'b0, w}) ? GB'(x2_s - {1'b0, w}) : x2_s[GB-1:0];
	assign y2_n = (y2_s >= {1'b0, h}) ? GB'(y2_s - {1'b0, h}) : y2_s[GB-1:0];

	// fade products
	logic [GB-1:0]         fd, fp;
	logic [2*GB-1:0]       d2_n, p2_n, dp_n;
	logic [QW-1:0]         quad_n;
	logic [3*GB-1:0]       d3_n;
	logic [4*GB-1:0]       p4_n;
	logic [3*GB+QW-1:0]    num_full;
	logic [FW-1:0]         p5_n;

	assign fd       = fade_y_q ? dy_q : dx_q;
	assign fp       = fade_y_q ? py : px;
	assign d2_n     = fd * fd;
	assign p2_n     = fp * fp;
	assign dp_n     = fd * fp;
	assign quad_n   = QW'(FADE_C5) * QW'(d2_q) + QW'(FADE_C3) * QW'(p2_q)
		- QW'(FADE_C4) * QW'(dp_q);
	assign d3_n     = d2_q * fd_q;
	assign p4_n     = p2_q * p2_q;
	assign num_full = d3_q * quad_q;
	assign p5_n     = p4_q * fp_q;

	// lerp
	logic [SB-1:0]         la, lb;
	logic [FRAC_BITS-1:0]  lf;
	logic signed [SB:0]    ldiff;
	logic signed [LW-1:0]  lprod, lsum;
	logic [SB-1:0]         lres;

	always_comb begin
		case (lerp_cnt_q)
			2'd0: begin
				la = seed_q[0];
				lb = seed_q[1];
				lf = fx_q;
			end
			2'd1: begin
				la = seed_q[2];
				lb = seed_q[3];
				lf = fx_q;
			end
			default: begin
				la = top_q;
				lb = bot_q;
				lf = fy_q;
			end
		endcase
	end

	assign ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
	assign lprod = ldiff * $signed({1'b0, lf});
	assign lsum  = $signed({18'd0, la}) + (prod_q >>> FRAC_BITS);
	assign lres  = lsum[SB-1:0];

	// weight update
	logic [19:0]          wsh;
	logic [OCT_BITS-1:0]  oct_nx;
	logic                 out_load;

	assign wsh      = wprod_q[31:12];
	assign oct_nx   = oct_q + OCT_BITS'(1);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mod_start  = 1'b0;
		frac_start = 1'b0;
		in_stall   = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid && opcode == OP_COMPUTE) begin
					state_d = S_WX_GO;
				end
			end
			S_WX_GO: begin
				mod_start = 1'b1;
				state_d   = S_WX_WAIT;
			end
			S_WX_WAIT: begin
				if (mod_stat.done) begin
					state_d = S_WY_GO;
				end
			end
			S_WY_GO: begin
				mod_start = 1'b1;
				state_d   = S_WY_WAIT;
			end
			S_WY_WAIT: begin
				if (mod_stat.done) begin
					state_d = S_DX_GO;
				end
			end
			S_DX_GO: begin
				mod_start = 1'b1;
				state_d   = S_DX_WAIT;
			end
			S_DX_WAIT: begin
				if (mod_stat.done) begin
					state_d = S_DY_GO;
				end
			end
			S_DY_GO: begin
				mod_start = 1'b1;
				state_d   = S_DY_WAIT;
			end
			S_DY_WAIT: begin
				if (mod_stat.done) begin
					state_d = S_F1;
				end
			end
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_F3;
			S_F3:   state_d = S_F_GO;
			S_F_GO: begin
				frac_start = 1'b1;
				state_d    = S_F_WAIT;
			end
			S_F_WAIT: begin
				if (frac_stat.done) begin
					state_d = fade_y_q ? S_RD : S_F1;
				end
			end
			S_RD: begin
				if (rd_cnt_q == 3'd4) begin
					state_d = S_L_MUL;
				end
			end
			S_L_MUL: state_d = S_L_ADD;
			S_L_ADD: begin
				state_d = (lerp_cnt_q == 2'd2) ? S_ACC_MUL : S_L_MUL;
			end
			S_ACC_MUL: state_d = S_ACC_ADD;
			S_ACC_ADD: begin
				state_d = (oct_nx == n_oct) ? S_FIN_GO : S_DX_GO;
			end
			S_FIN_GO: begin
				frac_start = 1'b1;
				state_d    = S_FIN_WAIT;
			end
			S_FIN_WAIT: begin
				if (frac_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cx_q <= coord_x;
					cy_q <= coord_y;
				end
			end
			S_WX_WAIT: begin
				if (mod_stat.done) begin
					x_q <= mod_rem;
				end
			end
			S_WY_WAIT: begin
				if (mod_stat.done) begin
					y_q      <= mod_rem;
					oct_q    <= '0;
					weight_q <= WEIGHT_ONE;
					noise_q  <= '0;
					total_q  <= '0;
				end
			end
			S_DX_WAIT: begin
				if (mod_stat.done) begin
					dx_q <= mod_rem;
					x1_q <= x1_n;
					x2_q <= x2_n;
				end
			end
			S_DY_WAIT: begin
				if (mod_stat.done) begin
					dy_q     <= mod_rem;
					y1_q     <= y1_n;
					y2_q     <= y2_n;
					fade_y_q <= 1'b0;
				end
			end
			S_F1: begin
				d2_q <= d2_n;
				p2_q <= p2_n;
				dp_q <= dp_n;
				fd_q <= fd;
				fp_q <= fp;
			end
			S_F2: begin
				quad_q <= quad_n;
				d3_q   <= d3_n;
				p4_q   <= p4_n;
			end
			S_F3: begin
				num_q <= num_full[FW-1:0];
				p5_q  <= p5_n;
			end
			S_F_WAIT: begin
				if (frac_stat.done) begin
					if (fade_y_q) begin
						fy_q     <= frac_quot;
						rd_cnt_q <= '0;
					end else begin
						fx_q     <= frac_quot;
						fade_y_q <= 1'b1;
					end
				end
			end
			S_RD: begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
				// data of the previous address arrives now
				if (rd_cnt_q != 3'd0) begin
					seed_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata;
				end
				lerp_cnt_q <= '0;
			end
			S_L_MUL: begin
				prod_q <= lprod;
			end
			S_L_ADD: begin
				case (lerp_cnt_q)
					2'd0:    top_q  <= lres;
					2'd1:    bot_q  <= lres;
					default: lerp_q <= lres;
				endcase
				lerp_cnt_q <= lerp_cnt_q + 2'd1;
			end
			S_ACC_MUL: begin
				nprod_q <= lerp_q * weight_q;
				wprod_q <= weight_q * fo_q;
			end
			S_ACC_ADD: begin
				noise_q  <= noise_q + NW'(nprod_q);
				total_q  <= total_q + TB'(weight_q);
				weight_q <= (wsh[19:16] != 4'd0) ? 16'hFFFF : wsh[15:0];
				oct_q    <= oct_nx;
			end
			default: ;
		endcase
		if (out_load) begin
			height_q  <= frac_quot;
			point_x_q <= cx_q;
			point_y_q <= cy_q;
		end
	end

	assign out_valid = out_valid_q;
	assign height    = height_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;

	a_mod_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_stat.busy)
		else $error("remainder unit started while busy");

	a_frac_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		frac_start |-> !frac_stat.busy)
		else $error("fraction divider started while busy");

	a_mod_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == S_WX_WAIT || state_q == S_WY_WAIT
			|| state_q == S_DX_WAIT || state_q == S_DY_WAIT))
		else $error("remainder result arrived outside a wait step");

	a_frac_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		frac_stat.done |-> (state_q == S_F_WAIT || state_q == S_FIN_WAIT))
		else $error("fraction result arrived outside a wait step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("result dropped while output word stalled");

endmodule
`default_nettype wire

>>> hdl/ovng_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ovng_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ovng_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/ovng_moddiv.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ovng_moddiv
// Restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module ovng_moddiv #(
	parameter int DIVIDEND_BITS = 8,
	parameter int DIVISOR_BITS  = 9
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DIVIDEND_BITS-1:0] dividend,
	input  wire logic [DIVISOR_BITS-1:0]  divisor,
	output logic      [DIVISOR_BITS-1:0]  rem,
	output ovng_pkg::div_stat_t           stat
);
	import ovng_pkg::*;

	localparam int CB = $clog2(DIVIDEND_BITS + 1);

	logic [DIVIDEND_BITS-1:0] a_q;
	logic [DIVISOR_BITS-1:0]  b_q;
	logic [DIVISOR_BITS-1:0]  r_q;
	logic [CB-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DIVISOR_BITS:0]    trial;
	logic                     take;

	assign trial = {r_q, a_q[DIVIDEND_BITS-1]};
	assign take  = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(DIVIDEND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CB'(1);
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			b_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[DIVIDEND_BITS-2:0], 1'b0};
			r_q <= take ? DIVISOR_BITS'(trial - {1'b0, b_q}) : trial[DIVISOR_BITS-1:0];
		end
	end

	assign rem       = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

>>> hdl/ovng_fracdiv.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ovng_fracdiv
// Fraction divider: floor(num * 2^16 / den) for num < den, one bit a cycle.
// ---------------------------------------------------------------------------
module ovng_fracdiv #(
	parameter int DW = 44
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DW-1:0]                 num,
	input  wire logic [DW-1:0]                 den,
	output logic      [ovng_pkg::FRAC_BITS-1:0] quot,
	output ovng_pkg::div_stat_t                stat
);
	import ovng_pkg::*;

	localparam int CB = $clog2(FRAC_BITS + 1);

	logic [DW-1:0]        r_q;
	logic [DW-1:0]        den_q;
	logic [FRAC_BITS-1:0] q_q;
	logic [CB-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          trial;
	logic                 take;

	assign trial = {r_q, 1'b0};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CB'(1);
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num;
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			q_q <= {q_q[FRAC_BITS-2:0], take};
		end
	end

	assign quot      = q_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire
